// ===== design/jss_pkg.sv =====
// shared types and constants for the joystick smoothstep slew drive
// no dependencies; compiled first
package jss_pkg;

  localparam int CENTER_W = 10;
  localparam int DZ_W     = 9;
  localparam int RANGE_W  = 10;
  localparam int RAMP_W   = 16;
  localparam int PWM_W    = 8;
  localparam int LEVEL_W  = 16;
  localparam int DIR_W    = 2;
  localparam int T_W      = 17;
  localparam int K_W      = 18;
  localparam int PROD_W   = T_W + K_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [T_W-1:0] T_ONE   = 17'h10000;
  localparam logic [K_W-1:0] K_THREE = 18'h30000;

  localparam logic [CENTER_W-1:0] CENTER_RST   = 10'd512;
  localparam logic [DZ_W-1:0]     DEADZONE_RST = 9'd40;
  localparam logic [RANGE_W-1:0]  RANGE_RST    = 10'd470;
  localparam logic [RAMP_W-1:0]   RAMP_RST     = 16'd6144;
  localparam logic [PWM_W-1:0]    PWM_RST      = 8'd150;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER     = 3'd0,
    REG_DEADZONE   = 3'd1,
    REG_FULL_RANGE = 3'd2,
    REG_RAMP_STEP  = 3'd3,
    REG_PWM_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DZ,
    ST_DIV,
    ST_T2,
    ST_S,
    ST_TGT,
    ST_SLEW,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center;
    logic [DZ_W-1:0]     deadzone;
    logic [RANGE_W-1:0]  full_range;
    logic [RAMP_W-1:0]   ramp_step;
    logic [PWM_W-1:0]    pwm_limit;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic dz_chk;
    logic div_step;
    logic mul_t2;
    logic mul_s;
    logic mul_tgt;
    logic slew;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic dz;
    logic sat;
    logic out_free;
  } stat_t;

endpackage

// ===== design/jss_if.sv =====
// valid/ready channel interfaces for samples in and drive results out
// depends on jss_pkg
interface jss_sample_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface jss_drive_if;
  logic                           valid;
  logic                           ready;
  logic [jss_pkg::DIR_W-1:0]      direction;
  logic [jss_pkg::PWM_W-1:0]      duty;

  modport source (output valid, output direction, output duty, input ready);
  modport sink (input valid, input direction, input duty, output ready);
endinterface

// ===== design/jss_ctrl.sv =====
// sequencer for the drive: steps the shared divider and multiplier
// depends on jss_pkg
module jss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  jss_pkg::stat_t  stat,
  output jss_pkg::ctl_t   ctl
);
  import jss_pkg::*;

  state_t                 state, state_next;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic                   div_last;

  assign div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DZ;
      end
      ST_DZ: begin
        if (stat.dz) state_next = ST_FIN;
        else if (stat.sat) state_next = ST_T2;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) state_next = ST_T2;
      end
      ST_T2:   state_next = ST_S;
      ST_S:    state_next = ST_TGT;
      ST_TGT:  state_next = ST_SLEW;
      ST_SLEW: state_next = ST_FIN;
      ST_FIN: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.load_in = in_valid;
      end
      ST_DZ:   ctl.dz_chk   = 1'b1;
      ST_DIV:  ctl.div_step = 1'b1;
      ST_T2:   ctl.mul_t2   = 1'b1;
      ST_S:    ctl.mul_s    = 1'b1;
      ST_TGT:  ctl.mul_tgt  = 1'b1;
      ST_SLEW: ctl.slew     = 1'b1;
      ST_FIN:  ctl.load_out = stat.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

// ===== design/jss_dp.sv =====
// datapath: offset and deadzone, restoring divider, one shared multiplier,
// slew limiter and result register; depends on jss_pkg
module jss_dp #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  jss_pkg::ctl_t              ctl,
  output jss_pkg::stat_t             stat,
  input  jss_pkg::cfg_t              cfg,
  input  logic [SAMPLE_BITS-1:0]     raw,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [jss_pkg::DIR_W-1:0]  out_direction,
  output logic [jss_pkg::PWM_W-1:0]  out_duty
);
  import jss_pkg::*;

  localparam int MAG_W = (SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W;

  dir_t                 dir;
  logic [MAG_W-1:0]     mag;
  logic [RANGE_W-1:0]   rem;
  logic [T_W-1:0]       tq;
  logic [PROD_W-1:0]    prod;
  logic [LEVEL_W-1:0]   level;

  logic [MAG_W-1:0]     raw_x, center_x, excess;
  logic                 bad_range;
  logic [RANGE_W-1:0]   span;
  logic [RANGE_W:0]     rem_sh;
  logic                 rem_ge;
  logic [T_W-1:0]       mul_a;
  logic [K_W-1:0]       mul_b;
  logic [K_W-1:0]       k_val;
  logic [LEVEL_W-1:0]   target, level_next, diff, cap, capped;
  logic [LEVEL_W:0]     up;

  assign raw_x    = MAG_W'(raw);
  assign center_x = MAG_W'(cfg.center);

  // deadzone test and saturation of t
  assign excess    = mag - MAG_W'(cfg.deadzone);
  assign bad_range = (cfg.full_range <= RANGE_W'(cfg.deadzone));
  assign span      = cfg.full_range - RANGE_W'(cfg.deadzone);

  assign stat.dz       = (mag <= MAG_W'(cfg.deadzone));
  assign stat.sat      = bad_range || (excess >= MAG_W'(span));
  assign stat.out_free = !out_valid || out_ready;

  // one restoring divide step per cycle
  assign rem_sh = {rem, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, span});

  // shared multiplier operand select
  assign k_val = K_THREE - {tq, 1'b0};

  always_comb begin
    mul_a = tq;
    mul_b = K_W'(tq);
    if (ctl.mul_s) begin
      mul_a = prod[32:16];
      mul_b = k_val;
    end else if (ctl.mul_tgt) begin
      mul_a = prod[32:16];
      mul_b = K_W'(cfg.pwm_limit);
    end
  end

  // slew toward target
  assign target = prod[23:8];
  assign up     = {1'b0, level} + {1'b0, cfg.ramp_step};
  assign diff   = level - target;

  always_comb begin
    level_next = level;
    if (level < target) begin
      level_next = (up < {1'b0, target}) ? up[LEVEL_W-1:0] : target;
    end else if (level > target) begin
      level_next = (diff > cfg.ramp_step) ? (level - cfg.ramp_step) : target;
    end
  end

  assign cap    = {cfg.pwm_limit, 8'h00};
  assign capped = (level < cap) ? level : cap;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      if (raw_x >= center_x) begin
        mag <= raw_x - center_x;
        dir <= DIR_FWD;
      end else begin
        mag <= center_x - raw_x;
        dir <= DIR_REV;
      end
    end
    if (ctl.dz_chk) begin
      if (stat.dz) begin
        dir <= DIR_STOP;
      end
      rem <= excess[RANGE_W-1:0];
      tq  <= stat.sat ? T_ONE : '0;
    end
    if (ctl.div_step) begin
      rem <= rem_ge ? (rem_sh[RANGE_W-1:0] - span) : rem_sh[RANGE_W-1:0];
      tq  <= {tq[T_W-2:0], rem_ge};
    end
    if (ctl.mul_t2 || ctl.mul_s || ctl.mul_tgt) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (ctl.load_out) begin
      out_direction <= dir;
      out_duty      <= capped[LEVEL_W-1:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.dz_chk && stat.dz) begin
        level <= '0;
      end else if (ctl.slew) begin
        level <= level_next;
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/joystick_smoothstep_slew_drive.sv =====
// Joystick drive: one sample beat in, one direction/duty beat out. A sample is
// accepted only while the sequencer is idle. Outside the deadzone a sample goes
// from accept to the next accept through the deadzone check, the restoring
// divider that forms t one bit per cycle, three passes through the single
// shared 17x18 multiplier (t*t, smoothstep, pwm scale), the slew step, the load
// of the result register and the idle state that takes the next sample. When t
// saturates the divider is skipped; a sample inside the deadzone goes from the
// deadzone check straight to the load step. The result register lets the next
// sample in while a result waits to be taken; a sample that reaches the load step
// while that result is still waiting holds there until it is taken.
// Configuration writes are taken at any time but belong only to idle periods.
module joystick_smoothstep_slew_drive #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  jss_sample_if.sink                    sample,
  jss_drive_if.source                   drive,
  input  logic                          cfg_we,
  input  logic [jss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jss_pkg::*;

  cfg_t  cfg;
  ctl_t  ctl;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center     <= CENTER_RST;
      cfg.deadzone   <= DEADZONE_RST;
      cfg.full_range <= RANGE_RST;
      cfg.ramp_step  <= RAMP_RST;
      cfg.pwm_limit  <= PWM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER:     cfg.center     <= cfg_data[CENTER_W-1:0];
        REG_DEADZONE:   cfg.deadzone   <= cfg_data[DZ_W-1:0];
        REG_FULL_RANGE: cfg.full_range <= cfg_data[RANGE_W-1:0];
        REG_RAMP_STEP:  cfg.ramp_step  <= cfg_data[RAMP_W-1:0];
        REG_PWM_LIMIT:  cfg.pwm_limit  <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  jss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  jss_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cfg           (cfg),
    .raw           (sample.raw_sample),
    .out_ready     (drive.ready),
    .out_valid     (drive.valid),
    .out_direction (drive.direction),
    .out_duty      (drive.duty)
  );

endmodule

// ===== sim/joystick_smoothstep_slew_drive_test.sv =====
// self-checking bench for the joystick smoothstep slew drive: samples in, direction/duty out
// depends on jss_pkg, jss_sample_if, jss_drive_if and the drive block itself
`timescale 1ns / 100ps

module joystick_smoothstep_slew_drive_test;
  import jss_pkg::*;

  localparam int SAMPLE_BITS     = 10;
  localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
  localparam int STICK_PHASES    = 13;
  localparam int PHASE_SAMPLES   = 125;
  localparam int QUIET_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 40;
  localparam int REPORT_MAX      = 10;

  typedef struct packed {
    dir_t             direction;
    logic [PWM_W-1:0] duty;
  } drive_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  jss_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  jss_drive_if drive_ch ();

  joystick_smoothstep_slew_drive #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .drive     (drive_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  cfg_t             drive_cfg;
  logic [LEVEL_W-1:0] slew_level;
  drive_beat_t      pending_drive[$];
  bit               idle_on;
  int               mismatches;
  int               samples_sent;
  int               beats_checked;
  int               settings_used;
  int               dir_seen[3];
  int               quiet_cycles;
  int               stall_left;

  function automatic cfg_t make_cfg(input logic [CENTER_W-1:0] center,
                                    input logic [DZ_W-1:0] deadzone,
                                    input logic [RANGE_W-1:0] full_range,
                                    input logic [RAMP_W-1:0] ramp_step,
                                    input logic [PWM_W-1:0] pwm_limit);
    cfg_t c;
    c.center     = center;
    c.deadzone   = deadzone;
    c.full_range = full_range;
    c.ramp_step  = ramp_step;
    c.pwm_limit  = pwm_limit;
    return c;
  endfunction

  // expected direction/duty for one sample; advances the slew level
  function automatic drive_beat_t next_drive(input logic [SAMPLE_BITS-1:0] raw);
    drive_beat_t beat;
    logic [63:0] mag, t, t2, k, s, tgt, lv, cap;
    if (raw >= drive_cfg.center) begin
      mag = 64'(raw) - 64'(drive_cfg.center);
      beat.direction = DIR_FWD;
    end else begin
      mag = 64'(drive_cfg.center) - 64'(raw);
      beat.direction = DIR_REV;
    end
    if (mag <= 64'(drive_cfg.deadzone)) begin
      slew_level = '0;
      beat.direction = DIR_STOP;
      beat.duty = '0;
      return beat;
    end
    if (drive_cfg.full_range <= drive_cfg.deadzone) begin
      t = 64'(T_ONE);
    end else begin
      t = ((mag - 64'(drive_cfg.deadzone)) << 16) /
          (64'(drive_cfg.full_range) - 64'(drive_cfg.deadzone));
      if (t > 64'(T_ONE)) t = 64'(T_ONE);
    end
    t2  = (t * t) >> 16;
    k   = 64'(K_THREE) - (t << 1);
    s   = (t2 * k) >> 16;
    tgt = (s * 64'(drive_cfg.pwm_limit)) >> 8;
    lv  = 64'(slew_level);
    if (lv < tgt) begin
      lv = lv + 64'(drive_cfg.ramp_step);
      if (lv > tgt) lv = tgt;
    end else if (lv > tgt) begin
      if (lv - tgt > 64'(drive_cfg.ramp_step)) lv = lv - 64'(drive_cfg.ramp_step);
      else lv = tgt;
    end
    slew_level = lv[LEVEL_W-1:0];
    cap = 64'(drive_cfg.pwm_limit) << 8;
    if (lv > cap) lv = cap;
    beat.duty = lv[15:8];
    return beat;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_MAX) $display("%s", msg);
    mismatches++;
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.raw_sample <= raw;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    pending_drive.push_back(next_drive(raw));
    samples_sent++;
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= data;
    case (r)
      REG_CENTER:     drive_cfg.center     = data[CENTER_W-1:0];
      REG_DEADZONE:   drive_cfg.deadzone   = data[DZ_W-1:0];
      REG_FULL_RANGE: drive_cfg.full_range = data[RANGE_W-1:0];
      REG_RAMP_STEP:  drive_cfg.ramp_step  = data[RAMP_W-1:0];
      REG_PWM_LIMIT:  drive_cfg.pwm_limit  = data[PWM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // junk in the unused upper data bits must be dropped by the block
  task automatic apply_config(input cfg_t c, input bit junk);
    logic [CFG_DATA_W-1:0] hi;
    hi = junk ? CFG_DATA_W'($urandom) : '0;
    put_reg(REG_CENTER,     {hi[CFG_DATA_W-1:CENTER_W], c.center});
    put_reg(REG_DEADZONE,   {hi[CFG_DATA_W-1:DZ_W], c.deadzone});
    put_reg(REG_FULL_RANGE, {hi[CFG_DATA_W-1:RANGE_W], c.full_range});
    put_reg(REG_RAMP_STEP,  c.ramp_step);
    put_reg(REG_PWM_LIMIT,  {hi[CFG_DATA_W-1:PWM_W], c.pwm_limit});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_sample(10'd512);
    send_sample(10'd552);
    send_sample(10'd553);
    send_sample(10'd472);
    send_sample(10'd471);
    repeat (5) send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(10'd0);
    send_sample(10'd982);
    send_sample(10'd700);
  endtask

  task automatic test_special_cases();
    // full_range not above deadzone: anything outside saturates, full ramp jumps
    drain_results();
    apply_config(make_cfg(10'd512, 9'd300, 10'd200, 16'hffff, 8'd255), 1'b0);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd812);
    // zero ramp, zero limit, smallest range, center at the bottom
    drain_results();
    apply_config(make_cfg(10'd0, 9'd0, 10'd1, 16'd0, 8'd0), 1'b0);
    send_sample(10'd0);
    send_sample(10'd1);
    send_sample(10'd1023);
    // limit below ten with zero ramp holds the level, center at the top
    drain_results();
    apply_config(make_cfg(10'd1023, 9'd0, 10'd1023, 16'd0, 8'd9), 1'b0);
    send_sample(10'd0);
    send_sample(10'd1022);
    // widest deadzone, smallest ramp
    drain_results();
    apply_config(make_cfg(10'd1023, 9'd511, 10'd512, 16'd1, 8'd255), 1'b0);
    send_sample(10'd0);
    send_sample(10'd511);
    send_sample(10'd512);
  endtask

  function automatic cfg_t pick_config(input int ph);
    cfg_t c;
    int r, dz;
    if (ph == 0) return make_cfg(10'd0, 9'd0, 10'd0, 16'd1, 8'd1);
    if (ph == 1) return make_cfg(10'd1023, 9'd511, 10'd1023, 16'hffff, 8'd255);
    if (ph == 2) return make_cfg(CENTER_RST, DEADZONE_RST, RANGE_RST, RAMP_RST, PWM_RST);
    r = $urandom_range(0, 5);
    c.center = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : CENTER_W'($urandom_range(200, 820));
    r = $urandom_range(0, 9);
    dz = (r == 0) ? 0 : (r == 1) ? 511 : $urandom_range(0, 150);
    c.deadzone = DZ_W'(dz);
    r = $urandom_range(0, 7);
    if (r == 0) c.full_range = RANGE_W'($urandom_range(0, 1023));
    else if (r == 1) c.full_range = 10'd512;
    else if (r == 2) c.full_range = RANGE_W'(dz + 1);
    else c.full_range = RANGE_W'(dz + $urandom_range(1, 512 - dz));
    r = $urandom_range(0, 7);
    c.ramp_step = (r == 0) ? 16'd0 : (r == 1) ? 16'hffff : (r == 2) ? 16'd1 :
                  RAMP_W'($urandom_range(64, 16384));
    r = $urandom_range(0, 7);
    c.pwm_limit = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
                  (r == 2) ? PWM_W'($urandom_range(1, 9)) : PWM_W'($urandom_range(10, 255));
    return c;
  endfunction

  // stick motion: walks and holds that let the level settle, plus noise, deadzone-edge samples and slams
  task automatic drive_stick_phase(input int n);
    int pos, kind, seg_len, sent, dz;
    sent = 0;
    pos = drive_cfg.center;
    dz = drive_cfg.deadzone;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      seg_len = $urandom_range(4, 20);
      for (int i = 0; i < seg_len && sent < n; i++) begin
        case (kind)
          0, 1, 2, 3, 4: pos = pos + int'($urandom_range(0, 48)) - 24;
          5, 6: begin
            if (i == 0) begin
              case ($urandom_range(0, 2))
                0: pos = 0;
                1: pos = SAMPLE_MAX;
                default: pos = $urandom_range(0, SAMPLE_MAX);
              endcase
            end
          end
          7: pos = $urandom_range(0, SAMPLE_MAX);
          8: pos = int'(drive_cfg.center) - dz + int'($urandom_range(0, 2 * dz + 2)) - 1;
          default: pos = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        endcase
        if (pos < 0) pos = 0;
        if (pos > SAMPLE_MAX) pos = SAMPLE_MAX;
        send_sample(SAMPLE_BITS'(pos));
        sent++;
      end
    end
  endtask

  task automatic test_random_phases();
    cfg_t c;
    for (int ph = 0; ph < STICK_PHASES; ph++) begin
      drain_results();
      c = pick_config(ph);
      idle_on = (ph % 4 != 3);
      apply_config(c, ph % 2 == 1);
      drive_stick_phase(PHASE_SAMPLES);
    end
  endtask

  always @(posedge clk) begin : drive_sink
    drive_beat_t want;
    int gap;
    if (rst) begin
      drive_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (drive_ch.valid && drive_ch.ready) begin
      beats_checked++;
      if (pending_drive.size() == 0) begin
        report_mismatch($sformatf("drive beat with nothing expected: direction %0d duty %0d",
                                  drive_ch.direction, drive_ch.duty));
      end else begin
        want = pending_drive.pop_front();
        if (want.direction <= DIR_REV) dir_seen[want.direction]++;
        if (drive_ch.direction !== want.direction || drive_ch.duty !== want.duty)
          report_mismatch($sformatf(
            "drive beat %0d: direction exp %0d got %0d, duty exp %0d got %0d",
            beats_checked, want.direction, drive_ch.direction, want.duty, drive_ch.duty));
      end
      gap = idle_on ? $urandom_range(0, 6) : 0;
      drive_ch.ready <= (gap == 0);
      stall_left = (gap > 0) ? gap - 1 : 0;
    end else if (!drive_ch.ready) begin
      if (stall_left == 0) drive_ch.ready <= 1'b1;
      else stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (sample_ch.valid && sample_ch.ready) ||
        (drive_ch.valid && drive_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("no beat for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_drive.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.raw_sample = '0;
    drive_ch.ready = 1'b0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    drive_cfg = make_cfg(CENTER_RST, DEADZONE_RST, RANGE_RST, RAMP_RST, PWM_RST);
    slew_level = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_special_cases();
    test_random_phases();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d samples over %0d register settings, %0d drive beats checked",
             samples_sent, settings_used + 1, beats_checked);
    $display("stop %0d, forward %0d, reverse %0d, mismatches %0d",
             dir_seen[DIR_STOP], dir_seen[DIR_FWD], dir_seen[DIR_REV], mismatches);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
